### sv/tu8_pkg.sv
package tu8_pkg;

  // Source encodings selected by the mode register. Any other code decodes as big endian.
  typedef enum logic [1:0] {
    MODE_CP1252 = 2'd0,
    MODE_LE     = 2'd1,
    MODE_BE     = 2'd2
  } mode_e;

  localparam logic [7:0]  QMARK     = 8'h3F;
  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [5:0]  SURR_HI   = 6'b110110;
  localparam logic [5:0]  SURR_LO   = 6'b110111;
  localparam int unsigned QUEUE_DEPTH = 2;

  // One decoded request passed from the front to the back.
  // The back emits an optional '?' and then an optional code point.
  // After those, it emits an optional trailing '?'.
  typedef struct packed {
    logic        pre_q;
    logic        cp_vld;
    logic [20:0] cp;
    logic        post_q;
  } run_t;

  // windows-1252 to code point. The 0x80..0x9F block uses a fixed table.
  // All other bytes map as Latin-1.
  function automatic logic [15:0] cp1252_map(input logic [7:0] b);
    logic [15:0] r;
    r = {8'h00, b};
    if (b[7:5] == 3'b100) begin
      case (b[4:0])
        5'h00: r = 16'h20AC;  5'h01: r = 16'h0081;  5'h02: r = 16'h201A;
        5'h03: r = 16'h0192;  5'h04: r = 16'h201E;  5'h05: r = 16'h2026;
        5'h06: r = 16'h2020;  5'h07: r = 16'h2021;  5'h08: r = 16'h02C6;
        5'h09: r = 16'h2030;  5'h0A: r = 16'h0160;  5'h0B: r = 16'h2039;
        5'h0C: r = 16'h0152;  5'h0D: r = 16'h008D;  5'h0E: r = 16'h017D;
        5'h0F: r = 16'h008F;  5'h10: r = 16'h0090;  5'h11: r = 16'h2018;
        5'h12: r = 16'h2019;  5'h13: r = 16'h201C;  5'h14: r = 16'h201D;
        5'h15: r = 16'h2022;  5'h16: r = 16'h2013;  5'h17: r = 16'h2014;
        5'h18: r = 16'h02DC;  5'h19: r = 16'h2122;  5'h1A: r = 16'h0161;
        5'h1B: r = 16'h203A;  5'h1C: r = 16'h0153;  5'h1D: r = 16'h009D;
        5'h1E: r = 16'h017E;  5'h1F: r = 16'h0178;
        default: r = {8'h00, b};
      endcase
    end
    return r;
  endfunction

endpackage

### sv/tu8_front.sv
module tu8_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    in_byte_i,
  input  logic          end_of_data_i,
  input  logic          q_full_i,
  output logic          push_o,
  output tu8_pkg::run_t push_run_o
);
  import tu8_pkg::*;

  logic [1:0] mode_q;
  logic       phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic       hp_q, hp_d;
  logic [9:0] payload_q, payload_d;
  logic [15:0] unit;
  logic        is_hi, is_lo, accept;
  run_t        run;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Assemble the code unit in the selected byte order.
  assign unit  = (mode_q == MODE_LE) ? {in_byte_i, held_q} : {held_q, in_byte_i};
  assign is_hi = (unit[15:10] == SURR_HI);
  assign is_lo = (unit[15:10] == SURR_LO);

  // Classify the byte and compute the next pairing state.
  always_comb begin
    phase_d   = phase_q;
    held_d    = held_q;
    hp_d      = hp_q;
    payload_d = payload_q;
    run       = '0;
    if (mode_q == MODE_CP1252) begin
      run.cp_vld = 1'b1;
      run.cp     = {5'd0, cp1252_map(in_byte_i)};
    end else if (!phase_q) begin
      held_d  = in_byte_i;
      phase_d = 1'b1;
    end else begin
      phase_d = 1'b0;
      hp_d    = 1'b0;
      if (hp_q && is_lo) begin
        run.cp_vld = 1'b1;
        run.cp     = SUPP_BASE + {1'b0, payload_q, unit[9:0]};
      end else begin
        run.pre_q = hp_q;
        if (is_hi) begin
          hp_d      = 1'b1;
          payload_d = unit[9:0];
        end else if (is_lo) begin
          run.cp_vld = 1'b1;
          run.cp     = {13'd0, QMARK};
        end else begin
          run.cp_vld = 1'b1;
          run.cp     = {5'd0, unit};
        end
      end
    end
    // End of data flushes a waiting high surrogate and clears pairing.
    if (end_of_data_i) begin
      run.post_q = hp_d;
      phase_d    = 1'b0;
      held_d     = '0;
      hp_d       = 1'b0;
      payload_d  = '0;
    end
  end

  assign push_o     = accept && (run.pre_q || run.cp_vld || run.post_q);
  assign push_run_o = run;

  // Mode register and pairing state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_CP1252;
      phase_q   <= 1'b0;
      held_q    <= '0;
      hp_q      <= 1'b0;
      payload_q <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (accept) begin
        phase_q   <= phase_d;
        held_q    <= held_d;
        hp_q      <= hp_d;
        payload_q <= payload_d;
      end
    end
  end

endmodule

### sv/tu8_queue.sv
module tu8_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tu8_pkg::run_t push_run_i,
  output logic          full_o,
  output logic          empty_o,
  input  logic          pop_i,
  output tu8_pkg::run_t head_o
);
  import tu8_pkg::*;

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);

  run_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // Entry storage. The queue holds payload only, so it has no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_run_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### sv/tu8_back.sv
module tu8_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  tu8_pkg::run_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    utf8_byte_o,
  output logic          last_of_run_o
);
  import tu8_pkg::*;

  logic [7:0] enc [4];
  logic [2:0] enc_n;
  logic [7:0] seq [4];
  logic [2:0] cnt;
  logic [1:0] idx_q;
  logic       out_valid_q, out_last_q, load, is_last;
  logic [7:0] out_byte_q;
  logic [20:0] cp;

  assign cp = head_i.cp;

  // UTF-8 encoding of the code point.
  always_comb begin
    enc[0] = cp[7:0];
    enc[1] = '0;
    enc[2] = '0;
    enc[3] = '0;
    enc_n  = 3'd1;
    if (cp[20:7] == '0) begin
      enc_n = 3'd1;
    end else if (cp[20:11] == '0) begin
      enc[0] = {3'b110, cp[10:6]};
      enc[1] = {2'b10, cp[5:0]};
      enc_n  = 3'd2;
    end else if (cp[20:16] == '0) begin
      enc[0] = {4'b1110, cp[15:12]};
      enc[1] = {2'b10, cp[11:6]};
      enc[2] = {2'b10, cp[5:0]};
      enc_n  = 3'd3;
    end else begin
      enc[0] = {5'b11110, cp[20:18]};
      enc[1] = {2'b10, cp[17:12]};
      enc[2] = {2'b10, cp[11:6]};
      enc[3] = {2'b10, cp[5:0]};
      enc_n  = 3'd4;
    end
  end

  // Lay out the full byte run of the head request. A run never exceeds four bytes.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      seq[i] = '0;
    end
    cnt = '0;
    if (head_i.pre_q) begin
      seq[cnt[1:0]] = QMARK;
      cnt = cnt + 3'd1;
    end
    for (int i = 0; i < 4; i++) begin
      if (head_i.cp_vld && (3'(i) < enc_n)) begin
        seq[cnt[1:0]] = enc[i];
        cnt = cnt + 3'd1;
      end
    end
    if (head_i.post_q) begin
      seq[cnt[1:0]] = QMARK;
      cnt = cnt + 3'd1;
    end
  end

  assign load    = !empty_i && (!out_valid_q || !out_stall_i);
  assign is_last = ({1'b0, idx_q} == cnt - 3'd1);
  assign pop_o   = load && is_last;

  // Output register. It advances one byte a cycle unless the receiver stalls.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= is_last ? '0 : idx_q + 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= seq[idx_q];
      out_last_q <= is_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign utf8_byte_o   = out_byte_q;
  assign last_of_run_o = out_last_q;

endmodule

### sv/text_to_utf8_transcoder.sv
// Text to UTF-8 transcoder.
// The input channel (in_valid_i, in_stall_o, in_byte_i, end_of_data_i) takes one
// source byte per request. The output channel (out_valid_o, out_stall_i,
// utf8_byte_o, last_of_run_o) delivers one UTF-8 byte per request.
// last_of_run_o marks the final byte that one input byte caused. A source byte
// that completes nothing gives no output.
// The mode register is written through cfg_we_i and cfg_wdata_i while the block
// is idle. Mode 0 is windows-1252, mode 1 is UTF-16 little endian, and mode 2 is
// UTF-16 big endian.
// The front decodes one byte per cycle into a run request. The request goes into
// a two-entry queue. The back expands each request into one to four bytes.
// Throughput: one input byte per cycle while the queue has room. The output
// registers deliver one byte per cycle unless the receiver stalls, so an item
// that expands to N bytes occupies the back until all N bytes are loaded.
// When the back is free, the first byte of a run is registered in the queue and
// then in the output register before it is valid.
// Reset clears the mode to windows-1252 and clears the pairing state and queue.
// When the receiver stalls, the output byte holds and the queue fills. The input
// stalls once the queue is full.
module text_to_utf8_transcoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] utf8_byte_o,
  output logic       last_of_run_o
);
  import tu8_pkg::*;

  logic q_full, q_empty, push, pop;
  run_t push_run, head_run;

  // Decode front.
  tu8_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .end_of_data_i(end_of_data_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_run_o   (push_run)
  );

  // Request queue between front and back.
  tu8_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_run_i(push_run),
    .full_o    (q_full),
    .empty_o   (q_empty),
    .pop_i     (pop),
    .head_o    (head_run)
  );

  // Byte emitter.
  tu8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .head_i       (head_run),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .utf8_byte_o  (utf8_byte_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

### sv/tu8_checker.sv
module tu8_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] utf8_byte_o,
  input logic       last_of_run_o
);

  // No output request is offered while reset is held.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

  // A stalled output request keeps its byte and flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(utf8_byte_o)
      && $stable(last_of_run_o))
    else $error("stalled output changed");

  // A lead byte is always followed by continuation bytes of the same run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (utf8_byte_o[7:6] == 2'b11) |-> !last_of_run_o)
    else $error("lead byte ends a run");

  // No overlong two-byte lead and no lead beyond U+10FFFF.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (utf8_byte_o != 8'hC0) && (utf8_byte_o != 8'hC1)
      && (utf8_byte_o < 8'hF5))
    else $error("invalid UTF-8 byte");

  // The input only stalls while an output request is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no output pending");

endmodule

bind text_to_utf8_transcoder tu8_checker u_tu8_checker (.*);

### sim/text_to_utf8_transcoder_tb.sv
`timescale 1ns / 1ps

module text_to_utf8_transcoder_tb;
  import tu8_pkg::*;

  localparam int unsigned CLK_PERIOD    = 4;
  localparam int unsigned RESET_CYCLES  = 4;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LONG_HOLD     = 80;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned PHASE_ITEMS   = 26;
  localparam int unsigned MAX_REPORTS   = 10;

  // Mode code that the block does not name; it decodes as big endian.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Code points for the windows-1252 bytes 0x80 to 0x9F.
  localparam logic [15:0] WIN1252_HIGH [32] = '{
    16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
    16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
  };

  typedef struct packed {
    logic [7:0] data;
    logic       eod;
  } src_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } utf8_out_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_ALTERNATE
  } rx_style_e;

  logic       clk_i         = 1'b0;
  logic       rst_ni;
  logic       cfg_we_i      = 1'b0;
  logic [1:0] cfg_wdata_i   = 2'd0;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_byte_i     = 8'h00;
  logic       end_of_data_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic [7:0] utf8_byte_o;
  logic       last_of_run_o;

  // Source bytes waiting to be sent and UTF-8 bytes waiting to arrive.
  src_byte_t  pending_src[$];
  utf8_out_t  utf8_expected[$];
  int         queued_cnt = 0;
  int         fail_cnt   = 0;
  int         cycle_cnt  = 0;

  // Mirror of the mode register and of the decoder state.
  logic [1:0] src_mode     = MODE_CP1252;
  logic       pair_second  = 1'b0;
  logic [7:0] held_first   = 8'h00;
  logic       surr_waiting = 1'b0;
  logic [9:0] surr_bits    = 10'd0;

  // Bytes that one source byte produces.
  logic [7:0] run_buf [4];
  int         run_len;

  // Sender burst state.
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  // Receiver stall state.
  int          holds_wanted   = 0;
  int          holds_done     = 0;
  int unsigned long_hold_left = 0;
  int unsigned rx_cycle       = 0;
  rx_style_e   rx_style       = RX_FREE;

  text_to_utf8_transcoder i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_byte_i    (in_byte_i),
    .end_of_data_i(end_of_data_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .utf8_byte_o  (utf8_byte_o),
    .last_of_run_o(last_of_run_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // A step never yields more than four bytes.
  function automatic void emit_byte(input logic [7:0] b);
    if (run_len < 4) begin
      run_buf[run_len] = b;
      run_len++;
    end
  endfunction

  // Encode one code point as a UTF-8 sequence of one to four bytes.
  function automatic void emit_code_point(input logic [20:0] cp);
    if (cp < 21'h80) begin
      emit_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      emit_byte({3'b110, cp[10:6]});
      emit_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      emit_byte({4'b1110, cp[15:12]});
      emit_byte({2'b10, cp[11:6]});
      emit_byte({2'b10, cp[5:0]});
    end else begin
      emit_byte({5'b11110, cp[20:18]});
      emit_byte({2'b10, cp[17:12]});
      emit_byte({2'b10, cp[11:6]});
      emit_byte({2'b10, cp[5:0]});
    end
  endfunction

  // Handle one UTF-16 code unit, pairing surrogates.
  function automatic void decode_code_unit(input logic [15:0] u);
    logic is_high;
    logic is_low;
    is_high = (u >= 16'hD800) && (u <= 16'hDBFF);
    is_low  = (u >= 16'hDC00) && (u <= 16'hDFFF);
    if (surr_waiting && is_low) begin
      surr_waiting = 1'b0;
      emit_code_point(21'h10000 + {1'b0, surr_bits, u[9:0]});
    end else begin
      // A high surrogate without its partner becomes a question mark.
      if (surr_waiting) begin
        surr_waiting = 1'b0;
        emit_byte(QMARK);
      end
      if (is_high) begin
        surr_waiting = 1'b1;
        surr_bits    = u[9:0];
      end else if (is_low) begin
        emit_byte(QMARK);
      end else begin
        emit_code_point({5'd0, u});
      end
    end
  endfunction

  // Work out the UTF-8 bytes that one accepted source byte causes.
  function automatic void predict_utf8(input logic [7:0] b, input logic eod);
    utf8_out_t item;
    run_len = 0;
    if (src_mode == MODE_CP1252) begin
      if (b[7:5] == 3'b100) emit_code_point({5'd0, WIN1252_HIGH[b[4:0]]});
      else emit_code_point({13'd0, b});
    end else if (!pair_second) begin
      held_first  = b;
      pair_second = 1'b1;
    end else begin
      pair_second = 1'b0;
      if (src_mode == MODE_LE) decode_code_unit({b, held_first});
      else decode_code_unit({held_first, b});
    end
    // End of data flushes a waiting high surrogate and drops a held byte.
    if (eod) begin
      if (surr_waiting) emit_byte(QMARK);
      pair_second  = 1'b0;
      held_first   = 8'h00;
      surr_waiting = 1'b0;
      surr_bits    = 10'd0;
    end
    for (int i = 0; i < run_len; i++) begin
      item.data = run_buf[i];
      item.last = (i == run_len - 1);
      utf8_expected.push_back(item);
    end
  endfunction

  task automatic queue_byte(input logic [7:0] b, input logic eod);
    src_byte_t item;
    item.data = b;
    item.eod  = eod;
    pending_src.push_back(item);
    queued_cnt++;
  endtask

  // Send a code unit in the byte order of the current mode.
  task automatic queue_unit(input logic [15:0] u, input logic eod);
    if (src_mode == MODE_LE) begin
      queue_byte(u[7:0], 1'b0);
      queue_byte(u[15:8], eod);
    end else begin
      queue_byte(u[15:8], 1'b0);
      queue_byte(u[7:0], eod);
    end
  endtask

  // Wait until the sender is empty and every expected byte has arrived.
  task automatic wait_drained();
    while (pending_src.size() != 0 || in_valid_i || utf8_expected.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic [1:0] m);
    wait_drained();
    cfg_wdata_i <= m;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    src_mode    = m;
  endtask

  // Random windows-1252 text with many bytes from the remapped block.
  task automatic queue_win1252_text(input int n_items);
    int stop_at;
    logic [7:0] b;
    stop_at = queued_cnt + n_items;
    while (queued_cnt < stop_at) begin
      if ($urandom_range(0, 9) < 4) b = 8'($urandom_range(8'h80, 8'h9F));
      else b = 8'($urandom_range(0, 255));
      queue_byte(b, $urandom_range(0, 9) == 0);
    end
  endtask

  // Random UTF-16 text: mostly well formed, with broken surrogates and odd bytes.
  task automatic queue_utf16_text(input int n_items);
    int stop_at;
    int unsigned pick;
    logic eod;
    logic [15:0] u;
    stop_at = queued_cnt + n_items;
    while (queued_cnt < stop_at) begin
      pick = $urandom_range(0, 99);
      eod  = ($urandom_range(0, 11) == 0);
      if (pick < 35) begin
        case ($urandom_range(0, 3))
          0: u = 16'($urandom_range(16'h0000, 16'h007F));
          1: u = 16'($urandom_range(16'h0080, 16'h07FF));
          2: u = 16'($urandom_range(16'h0800, 16'hD7FF));
          default: u = 16'($urandom_range(16'hE000, 16'hFFFF));
        endcase
        queue_unit(u, eod);
      end else if (pick < 65) begin
        queue_unit(16'($urandom_range(16'hD800, 16'hDBFF)), 1'b0);
        queue_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), eod);
      end else if (pick < 75) begin
        queue_unit(16'($urandom_range(16'hD800, 16'hDBFF)), eod);
      end else if (pick < 85) begin
        queue_unit(16'($urandom_range(16'hDC00, 16'hDFFF)), eod);
      end else if (pick < 95) begin
        queue_unit(16'($urandom_range(0, 16'hFFFF)), eod);
      end else begin
        queue_byte(8'($urandom_range(0, 255)), 1'b1);
      end
    end
    // Sometimes leave half a unit held across the next mode change.
    if ($urandom_range(0, 1) == 0) queue_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Sender: offers queued requests in bursts, holding each until accepted.
  always @(posedge clk_i) begin : source_driver
    logic offer;
    offer = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_utf8(in_byte_i, end_of_data_i);
        void'(pending_src.pop_front());
      end
      offer = in_valid_i && in_stall_o;
      if (!offer) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_src.size() != 0) begin
          offer = 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 12);
          burst_left--;
          if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      if (offer) begin
        in_byte_i     <= pending_src[0].data;
        end_of_data_i <= pending_src[0].eod;
      end
    end
    in_valid_i <= offer;
  end

  // Receiver: stalls on a changing pattern, with long hold-offs on request.
  always @(posedge clk_i) begin : sink_stall
    logic hold;
    hold = 1'b0;
    if (rst_ni) begin
      rx_cycle++;
      if (rx_cycle % 48 == 0) rx_style = rx_style_e'($urandom_range(0, 3));
      if (long_hold_left != 0) begin
        long_hold_left--;
        hold = 1'b1;
      end else if (holds_done < holds_wanted && in_valid_i) begin
        holds_done++;
        long_hold_left = LONG_HOLD - 1;
        hold = 1'b1;
      end else begin
        case (rx_style)
          RX_FREE:  hold = 1'b0;
          RX_LIGHT: hold = ($urandom_range(0, 3) == 0);
          RX_HEAVY: hold = ($urandom_range(0, 3) != 0);
          default:  hold = rx_cycle[0];
        endcase
      end
    end
    out_stall_i <= hold;
  end

  // Monitor: compare each delivered byte with the oldest expectation.
  always @(posedge clk_i) begin : utf8_monitor
    utf8_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (utf8_expected.size() == 0) begin
        if (fail_cnt < MAX_REPORTS)
          $display("unexpected output byte %h last %b", utf8_byte_o, last_of_run_o);
        fail_cnt++;
      end else begin
        want = utf8_expected.pop_front();
        if (utf8_byte_o !== want.data || last_of_run_o !== want.last) begin
          if (fail_cnt < MAX_REPORTS)
            $display("mismatch: expected byte %h last %b, got byte %h last %b",
                     want.data, want.last, utf8_byte_o, last_of_run_o);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[text_to_utf8_transcoder] ERROR");
      $finish;
    end
  end

  initial begin
    // Drive reset low at time zero so the asynchronous reset sees an edge.
    rst_ni = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Windows-1252: range ends, both ends of the remapped block, Latin-1.
    set_mode(MODE_CP1252);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h81, 1'b0);
    queue_byte(8'h99, 1'b0);
    queue_byte(8'h9F, 1'b0);
    queue_byte(8'hA0, 1'b0);
    queue_byte(8'hFF, 1'b1);

    // UTF-16 little endian: largest code point, lone low surrogate,
    // high surrogate followed by a plain unit, high surrogate cut by end of
    // data, and an odd byte dropped at end of data.
    set_mode(MODE_LE);
    queue_unit(16'hDBFF, 1'b0);
    queue_unit(16'hDFFF, 1'b0);
    queue_unit(16'hDC00, 1'b0);
    queue_unit(16'hD800, 1'b0);
    queue_unit(16'hFFFF, 1'b0);
    queue_unit(16'hDBFF, 1'b1);
    queue_byte(8'h7F, 1'b1);

    // Random text in each mode, including the spare code, with long receiver hold-offs.
    set_mode(MODE_LE);
    holds_wanted++;
    queue_utf16_text(PHASE_ITEMS);
    set_mode(MODE_BE);
    queue_utf16_text(PHASE_ITEMS);
    set_mode(MODE_CP1252);
    holds_wanted++;
    queue_win1252_text(PHASE_ITEMS);
    set_mode(MODE_SPARE);
    queue_utf16_text(PHASE_ITEMS);
    set_mode(MODE_LE);
    queue_utf16_text(PHASE_ITEMS);
    set_mode(MODE_BE);
    queue_utf16_text(PHASE_ITEMS);

    wait_drained();
    if (fail_cnt == 0) begin
      $display("[text_to_utf8_transcoder] OK");
    end else begin
      $display("[text_to_utf8_transcoder] ERROR");
    end
    $finish;
  end

endmodule

### text_to_utf8_transcoder.f
sv/tu8_pkg.sv
sv/tu8_front.sv
sv/tu8_queue.sv
sv/tu8_back.sv
sv/text_to_utf8_transcoder.sv
sv/tu8_checker.sv
sim/text_to_utf8_transcoder_tb.sv
